/* hdl/lsoi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsoi_pkg
// Shared types and constants of the line-start offset indexer.
// ----------------------------------------------------------------------------
package lsoi_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int OFFSET_BITS = 32;

   // field widths
   localparam int BYTE_BITS   = 8;
   localparam int LINE_BITS   = 12;
   localparam int COLUMN_BITS = 32;
   localparam int REQ_DATA_BITS = 56;  // 52 bits of fields, padded to bytes
   localparam int RSP_DATA_BITS = 80;  // 78 bits of fields, padded to bytes

   localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'd10;

   // item kinds carried on req_tuser
   typedef enum logic [1:0] {
      KIND_TEXT    = 2'd0,
      KIND_END     = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC
   } state_type;

   // control from the sequencer to the lookup datapath
   typedef struct packed {
      logic                   capture;  // table read data valid this cycle
      logic                   is_end;
      logic                   closed;
      logic [LINE_BITS-1:0]   lines;
      logic                   overflow;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
   } lookup_ctrl_type;

   // one result item
   typedef struct packed {
      logic                   overflowed;
      logic [LINE_BITS-1:0]   total_lines;
      logic [OFFSET_BITS-1:0] length_of_line;
      logic                   inside_res;
      logic [OFFSET_BITS-1:0] byte_offset;
   } result_type;

endpackage

/* hdl/lsoi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsoi_ram
// Generic memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lsoi_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32,
   parameter int ABITS = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [ABITS-1:0] rd_addr_a,
   input  logic [ABITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/lsoi_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsoi_lookup
// Query datapath: line length and absolute offset from two table entries,
// then the range checks that form the result item.
// ----------------------------------------------------------------------------
module lsoi_lookup
   import lsoi_pkg::*;
(
   input  logic                   clock,
   input  lookup_ctrl_type        ctrl,
   input  logic [OFFSET_BITS-1:0] start_a,
   input  logic [OFFSET_BITS-1:0] start_b,
   output result_type             result
);

   logic [OFFSET_BITS-1:0] base;
   logic [OFFSET_BITS-1:0] len_in, len_ff;
   logic [OFFSET_BITS-1:0] off_in, off_ff;
   logic                   line_ok;
   logic                   col_ok;

   // entry 0 is always zero and never stored
   assign base   = (ctrl.line == '0) ? '0 : start_a;
   assign len_in = start_b - base;
   assign off_in = base + ctrl.column;

   // capture length and offset
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         len_ff <= len_in;
         off_ff <= off_in;
      end
   end

   // range checks and result formatting
   assign line_ok = ctrl.closed && (ctrl.line < ctrl.lines);
   assign col_ok  = line_ok && (ctrl.column < len_ff);

   always_comb begin
      result.overflowed     = ctrl.overflow;
      result.total_lines    = ctrl.closed ? ctrl.lines : '0;
      result.length_of_line = '0;
      result.inside_res     = 1'b0;
      result.byte_offset    = '0;
      if (!ctrl.is_end) begin
         result.length_of_line = line_ok ? len_ff : '0;
         result.inside_res     = col_ok;
         result.byte_offset    = col_ok ? off_ff : '0;
      end
   end

endmodule

/* hdl/line_start_offset_indexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_start_offset_indexer
// Builds a table of line-start offsets from a text stream and answers
// (line, column) position queries against it.
// ----------------------------------------------------------------------------
// Input channel req_*: one item per transfer, kind on req_tuser (text byte,
// end of stream, position query, restart). Result channel rsp_*: one
// transfer for each end or query item, none for text bytes and restarts.
// Text bytes and restarts are taken in the idle state, so a text stream is
// indexed at one byte per cycle while no end or query item is in progress.
// An end item passes the calc state and a query the read and calc states
// before input is taken again; a query's result passes the registered table
// read, the length/offset register and the range compare that loads the
// output register. The line-start table is a 4096 x 32 memory with one
// write and two read ports; entry 0 is held as constant zero.
// Reset clears the counters, the closed and overflow flags and any pending
// result. A restart item clears the counters and flags but leaves a waiting
// result in place; table contents are simply rewritten.
// The result sits in an output register: text bytes keep flowing while it
// waits, but a new end or query item holds in its final stage until the
// receiver takes the previous result.
// ----------------------------------------------------------------------------
module line_start_offset_indexer
   import lsoi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // text_byte, line_number, column_number
   input  logic [1:0]               req_tuser,  // kind
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // byte_offset, inside_res,
                                                // length_of_line, total_lines, overflowed
);

   // unpacked request fields
   kind_type               req_kind;
   logic [BYTE_BITS-1:0]   req_byte;
   logic [LINE_BITS-1:0]   req_line;
   logic [COLUMN_BITS-1:0] req_column;

   assign req_kind   = kind_type'(req_tuser);
   assign req_byte   = req_tdata[BYTE_BITS-1:0];
   assign req_line   = req_tdata[BYTE_BITS +: LINE_BITS];
   assign req_column = req_tdata[BYTE_BITS+LINE_BITS +: COLUMN_BITS];

   // state
   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [OFFSET_BITS-1:0] position_ff, position_in;
   logic                   closed_ff, closed_in;
   logic                   overflow_ff, overflow_in;
   logic                   is_end_ff, is_end_in;
   logic [LINE_BITS-1:0]   line_ff;
   logic [COLUMN_BITS-1:0] column_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff;

   logic                   accept;
   logic                   out_free;
   logic                   out_load;
   logic                   capture;
   logic [OFFSET_BITS-1:0] position_inc;
   logic                   wr_en;
   logic [OFFSET_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0]   rd_addr_b;
   logic [OFFSET_BITS-1:0] start_a;
   logic [OFFSET_BITS-1:0] start_b;
   lookup_ctrl_type        lookup_ctrl;
   result_type             result;

   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign position_inc = position_ff + 1'b1;
   assign rd_addr_b    = ADDR_BITS'({1'b0, req_line} + 1'b1);

   // sequencer: next state, table updates, handshake
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      position_in = position_ff;
      closed_in   = closed_ff;
      overflow_in = overflow_ff;
      is_end_in   = is_end_ff;
      req_tready  = 1'b0;
      out_load    = 1'b0;
      capture     = 1'b0;
      wr_en       = 1'b0;
      wr_data     = position_inc;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_kind)
                  KIND_TEXT: begin
                     if (!closed_ff) begin
                        if (position_ff == '1) begin
                           overflow_in = 1'b1;
                        end else begin
                           position_in = position_inc;
                           if (req_byte == NEWLINE_BYTE) begin
                              if (count_ff < COUNT_BITS'(TABLE_DEPTH - 1)) begin
                                 wr_en    = 1'b1;
                                 count_in = count_ff + 1'b1;
                              end else begin
                                 overflow_in = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  KIND_END: begin
                     is_end_in = 1'b1;
                     state_in  = ST_CALC;
                     if (!closed_ff && count_ff < COUNT_BITS'(TABLE_DEPTH)) begin
                        wr_en     = 1'b1;
                        wr_data   = position_ff;
                        count_in  = count_ff + 1'b1;
                        closed_in = 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     is_end_in = 1'b0;
                     state_in  = ST_READ;
                  end
                  KIND_RESTART: begin
                     count_in    = COUNT_BITS'(1);
                     position_in = '0;
                     closed_in   = 1'b0;
                     overflow_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            capture  = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= COUNT_BITS'(1);
         position_ff <= '0;
         closed_ff   <= 1'b0;
         overflow_ff <= 1'b0;
         is_end_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         position_ff <= position_in;
         closed_ff   <= closed_in;
         overflow_ff <= overflow_in;
         is_end_ff   <= is_end_in;
      end
   end

   // hold the query fields for the lookup stages
   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_QUERY) begin
         line_ff   <= req_line;
         column_ff <= req_column;
      end
   end

   lsoi_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (OFFSET_BITS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[ADDR_BITS-1:0]),
      .wr_data   (wr_data),
      .rd_en     (accept && req_kind == KIND_QUERY),
      .rd_addr_a (req_line[ADDR_BITS-1:0]),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (start_a),
      .rd_data_b (start_b)
   );

   assign lookup_ctrl.capture  = capture;
   assign lookup_ctrl.is_end   = is_end_ff;
   assign lookup_ctrl.closed   = closed_ff;
   assign lookup_ctrl.lines    = LINE_BITS'(count_ff - 1'b1);
   assign lookup_ctrl.overflow = overflow_ff;
   assign lookup_ctrl.line     = line_ff;
   assign lookup_ctrl.column   = column_ff;

   lsoi_lookup u_lookup (
      .clock   (clock),
      .ctrl    (lookup_ctrl),
      .start_a (start_a),
      .start_b (start_b),
      .result  (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

/* hdl/lsoi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsoi_checker
// Port-level checks of the line-start offset indexer, bound to the top level.
// ----------------------------------------------------------------------------
module lsoi_checker
   import lsoi_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic lookup_accept;

   assign lookup_accept = req_tvalid && req_tready &&
      (req_tuser == KIND_END || req_tuser == KIND_QUERY);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no input is accepted right after an end or query item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_accept |=> !req_tready)
      else $error("input accepted while a lookup is in flight");

   // an outside result carries a zero offset
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[31:0] == '0)
      else $error("nonzero offset on an outside result");

   // an inside result lies in a line of nonzero length
   a_inside_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[64:33] != '0)
      else $error("inside result with empty line");

   // reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind line_start_offset_indexer lsoi_checker u_lsoi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
